FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off while rst is high
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Implication: when ante holds, cons must hold at the same edge
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/ptphc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptphc_pkg
// Widths and command codes of the precision time clock.
// ----------------------------------------------------------------------------
package ptphc_pkg;

   // Fraction bits of the nanosecond counter (increment is in 2^-FRAC_BITS ns)
   localparam int FRAC_BITS   = 32;
   localparam int TIME_W      = 64;
   localparam int ADJ_MAG_W   = 31;
   localparam int CMD_W       = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK       = 3'd0,
      CMD_READ_TIME  = 3'd1,
      CMD_WRITE_TIME = 3'd2,
      CMD_READ_ADJ   = 3'd3,
      CMD_WRITE_ADJ  = 3'd4,
      CMD_WRITE_INC  = 3'd5
   } cmd_type;

endpackage

FILE: src/ptp_hardware_clock.sv
`timescale 1ns / 1ps
// A read is held in the item stage, then loaded into the result register.
// Throughput: one item per cycle; the item stage stalls only while it holds a
// read and the result register is full and not being taken.
// Reset: synchronous, active high; clears time, fraction, offset, increment,
// adjustment and all valid flags.
// ----------------------------------------------------------------------------
// ptp_hardware_clock
// Nanosecond counter with fractional increment, slewing adjustment and a
// software offset, driven by a stream of tick and register access items.
// ----------------------------------------------------------------------------
module ptp_hardware_clock (
   input  logic        clock,
   input  logic        reset,
   // item input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] value
   input  logic [2:0]  req_tuser,   // [2:0] cmd
   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [63:0] read_data
);

   localparam int FB = ptphc_pkg::FRAC_BITS;
   localparam int TW = ptphc_pkg::TIME_W;
   localparam int AW = ptphc_pkg::ADJ_MAG_W;

   // item stage
   logic                  stage_valid_ff, stage_valid_in;
   ptphc_pkg::cmd_type    stage_cmd_ff, stage_cmd_in;
   logic [TW-1:0]         stage_value_ff, stage_value_in;

   // clock state
   logic [TW-1:0]         time_ns_ff, time_ns_in;
   logic [FB-1:0]         time_frac_ff, time_frac_in;
   logic [TW-1:0]         time_offset_ff, time_offset_in;
   logic [TW-1:0]         increment_ff, increment_in;
   logic [AW-1:0]         adj_remaining_ff, adj_remaining_in;
   logic                  adj_negative_ff, adj_negative_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]         rsp_data_ff, rsp_data_in;

   logic                  stage_is_read;
   logic                  out_free;
   logic                  stage_fire;
   logic                  req_xfer;
   logic [FB:0]           frac_sum;
   logic [TW-1:0]         inc_whole;
   logic [TW-1:0]         adj_step;
   logic [TW-1:0]         tick_ns;

   // handshake control
   always_comb begin
      stage_is_read = stage_cmd_ff inside {ptphc_pkg::CMD_READ_TIME, ptphc_pkg::CMD_READ_ADJ};
      out_free      = !rsp_valid_ff || rsp_tready;
      stage_fire    = stage_valid_ff && (!stage_is_read || out_free);
      req_tready    = !stage_valid_ff || stage_fire;
      req_xfer      = req_tvalid && req_tready;
   end

   // tick arithmetic: fraction carry, whole increment and one-ns slew
   always_comb begin
      frac_sum  = {1'b0, time_frac_ff} + {1'b0, increment_ff[FB-1:0]};
      inc_whole = increment_ff >> FB;
      if (adj_remaining_ff == '0) begin
         adj_step = '0;
      end else if (adj_negative_ff) begin
         adj_step = '1;
      end else begin
         adj_step = TW'(1);
      end
      tick_ns = time_ns_ff + inc_whole + TW'(frac_sum[FB]) + adj_step;
   end

   // next state
   always_comb begin
      stage_valid_in   = stage_valid_ff && !stage_fire;
      stage_cmd_in     = stage_cmd_ff;
      stage_value_in   = stage_value_ff;
      time_ns_in       = time_ns_ff;
      time_frac_in     = time_frac_ff;
      time_offset_in   = time_offset_ff;
      increment_in     = increment_ff;
      adj_remaining_in = adj_remaining_ff;
      adj_negative_in  = adj_negative_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;

      // load the stage
      if (req_xfer) begin
         stage_valid_in = 1'b1;
         stage_cmd_in   = ptphc_pkg::cmd_type'(req_tuser);
         stage_value_in = req_tdata;
      end

      // execute the staged item
      if (stage_fire) begin
         case (stage_cmd_ff)
            ptphc_pkg::CMD_TICK: begin
               time_frac_in = frac_sum[FB-1:0];
               time_ns_in   = tick_ns;
               if (adj_remaining_ff != '0) begin
                  adj_remaining_in = adj_remaining_ff - AW'(1);
               end
            end
            ptphc_pkg::CMD_READ_TIME: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = time_ns_ff + time_offset_ff;
            end
            ptphc_pkg::CMD_WRITE_TIME: begin
               time_offset_in = stage_value_ff - time_ns_ff;
            end
            ptphc_pkg::CMD_READ_ADJ: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(TW-AW-1)'(0), adj_negative_ff, adj_remaining_ff};
            end
            ptphc_pkg::CMD_WRITE_ADJ: begin
               adj_remaining_in = stage_value_ff[AW-1:0];
               adj_negative_in  = stage_value_ff[AW];
            end
            ptphc_pkg::CMD_WRITE_INC: begin
               increment_in = stage_value_ff;
            end
            default: begin
               // unused codes: drop
            end
         endcase
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff   <= 1'b0;
         time_ns_ff       <= '0;
         time_frac_ff     <= '0;
         time_offset_ff   <= '0;
         increment_ff     <= '0;
         adj_remaining_ff <= '0;
         adj_negative_ff  <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         stage_valid_ff   <= stage_valid_in;
         time_ns_ff       <= time_ns_in;
         time_frac_ff     <= time_frac_in;
         time_offset_ff   <= time_offset_in;
         increment_ff     <= increment_in;
         adj_remaining_ff <= adj_remaining_in;
         adj_negative_ff  <= adj_negative_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      stage_cmd_ff   <= stage_cmd_in;
      stage_value_ff <= stage_value_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: src/ptphc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptphc_checker
// Port-level checks of the precision time clock, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptphc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   logic read_xfer;
   logic rsp_stall;

   // a read kind accepted on the input
   assign read_xfer = req_tvalid && req_tready &&
                      (req_tuser == ptphc_pkg::CMD_READ_TIME ||
                       req_tuser == ptphc_pkg::CMD_READ_ADJ);

   // a result offered and not taken
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // no result is offered right after reset
   `ASSERT_PROP(a_rsp_idle_after_reset, clock, reset, $past(reset) |-> !rsp_tvalid)

   // a stalled result holds its data
   `ASSERT_IMPL(a_rsp_hold, clock, reset, $past(rsp_stall), rsp_tvalid && $stable(rsp_tdata))

   // a fresh result follows a read transfer accepted earlier
   `ASSERT_IMPL(a_rsp_from_read, clock, reset, $rose(rsp_tvalid), $past(read_xfer, 2))

   // input never stalls while the result side can move
   `ASSERT_IMPL(a_req_ready, clock, reset, !rsp_tvalid || rsp_tready, req_tready)

endmodule

bind ptp_hardware_clock ptphc_checker u_ptphc_checker (.*);
